FILE: rtl/core/tlb_pkg.sv
// Shared types and constants for the fully associative TLB with LRU replacement.
// Used by tlb_seq and tlb_lru_lookup; no dependencies of its own.
package tlb_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned PAGE_OUT_W = 20;
  localparam int unsigned OFFS_OUT_W = 12;
  localparam int unsigned SLOT_OUT_W = 3;

  typedef struct packed {
    logic                  hit;
    logic [PAGE_OUT_W-1:0] page_number;
    logic [OFFS_OUT_W-1:0] page_offset;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic                  evicted;
  } tlb_result_t;

endpackage

FILE: rtl/core/tlb_lru_lookup.sv
// Top level of the fully associative TLB with LRU replacement: entry RAM, sequencer
// and result register. Depends on tlb_pkg, tlb_ram and tlb_seq.
//
//   Channel  Ports                                   Direction  Beat
//   in       in_valid, in_ready, in_virt_addr        input      one address
//   out      out_valid, out_ready, out_hit,          output     one lookup result
//            out_page_number, out_page_offset,
//            out_slot_used, out_evicted
//
// An access is taken in IDLE, which also issues the first read; in SCAN the single
// comparator then walks the RAM one entry at a time, and WRITE writes back the entry.
// A hit ends the walk early. Reset clears every valid bit, the use counter and the
// output valid flag at once; no clearing pass is needed.
// A stalled result holds the write-back until the output register frees up; a new
// address is still taken while a finished result waits.
module tlb_lru_lookup #(
  parameter int unsigned ENTRIES     = 5,
  parameter int unsigned OFFSET_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tlb_pkg::ADDR_W-1:0]        in_virt_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [tlb_pkg::PAGE_OUT_W-1:0]    out_page_number,
  output logic [tlb_pkg::OFFS_OUT_W-1:0]    out_page_offset,
  output logic [tlb_pkg::SLOT_OUT_W-1:0]    out_slot_used,
  output logic                              out_evicted
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PAGE_W = tlb_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned ENT_W  = PAGE_W + tlb_pkg::STAMP_W;

  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  logic [ENT_W-1:0]     ram_wr_data;
  logic                 ram_rd_en;
  logic [IDX_W-1:0]     ram_rd_addr;
  logic [ENT_W-1:0]     ram_rd_data;
  logic                 res_valid;
  logic                 res_ready;
  tlb_pkg::tlb_result_t res;
  tlb_pkg::tlb_result_t out_res_r;
  logic                 out_valid_r;

  tlb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tlb_seq #(
    .ENTRIES     (ENTRIES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_virt_addr (in_virt_addr),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_res_r.hit;
  assign out_page_number = out_res_r.page_number;
  assign out_page_offset = out_res_r.page_offset;
  assign out_slot_used   = out_res_r.slot_used;
  assign out_evicted     = out_res_r.evicted;

`ifndef NO_ASSERTIONS
  a_res_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready)
    else $error("result produced while output register is occupied");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !res_valid)
    else $error("result produced in the cycle after an address was accepted");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new address taken while a lookup is in progress");

  a_hit_not_evicted: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.hit && res.evicted))
    else $error("hit result also flags an eviction");
`endif

endmodule

FILE: rtl/core/tlb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/tlb_seq.sv
// Lookup sequencer: walks the entry RAM one slot per cycle, tracks hit, empty and LRU slot,
// then writes back page and stamp. Depends on tlb_pkg.
module tlb_seq #(
  parameter int unsigned ENTRIES     = 5,
  parameter int unsigned OFFSET_BITS = 12,
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned PAGE_W     = tlb_pkg::ADDR_W - OFFSET_BITS,
  localparam int unsigned ENT_W      = PAGE_W + tlb_pkg::STAMP_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tlb_pkg::ADDR_W-1:0]  in_virt_addr,
  output logic                        ram_wr_en,
  output logic [IDX_W-1:0]            ram_wr_addr,
  output logic [ENT_W-1:0]            ram_wr_data,
  output logic                        ram_rd_en,
  output logic [IDX_W-1:0]            ram_rd_addr,
  input  logic [ENT_W-1:0]            ram_rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tlb_pkg::tlb_result_t        res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  logic [ENTRIES-1:0]           valid_r;
  logic [PAGE_W-1:0]            page_r;
  logic [tlb_pkg::OFFS_OUT_W-1:0] offset_r;
  logic [tlb_pkg::STAMP_W-1:0]  use_count_r;
  logic [IDX_W-1:0]             idx_r;
  logic                         hit_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic                         have_empty_r;
  logic [IDX_W-1:0]             empty_idx_r;
  logic                         have_lru_r;
  logic [IDX_W-1:0]             lru_idx_r;
  logic [tlb_pkg::STAMP_W-1:0]  lru_stamp_r;

  logic                         in_beat;
  logic [tlb_pkg::ADDR_W-1:0]   page_full;
  logic [tlb_pkg::ADDR_W-1:0]   offset_full;
  logic [tlb_pkg::ADDR_W-1:0]   page_ext;
  logic [tlb_pkg::ADDR_W-1:0]   slot_ext;
  logic [PAGE_W-1:0]            rd_page;
  logic [tlb_pkg::STAMP_W-1:0]  rd_stamp;
  logic                         cur_valid;
  logic                         cur_match;
  logic                         scan_last;
  logic [IDX_W-1:0]             slot;
  logic                         commit;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_beat     = in_valid && in_ready;
  assign page_full   = in_virt_addr >> OFFSET_BITS;
  assign offset_full = in_virt_addr & ((tlb_pkg::ADDR_W'(1) << OFFSET_BITS) - tlb_pkg::ADDR_W'(1));

  assign rd_page   = ram_rd_data[ENT_W-1:tlb_pkg::STAMP_W];
  assign rd_stamp  = ram_rd_data[tlb_pkg::STAMP_W-1:0];
  assign cur_valid = valid_r[idx_r];
  assign cur_match = cur_valid && (rd_page == page_r);
  assign scan_last = (idx_r == LAST_IDX);

  assign slot   = hit_r ? hit_idx_r : (have_empty_r ? empty_idx_r : lru_idx_r);
  assign commit = (state_r == ST_WRITE) && res_ready;

  assign ram_rd_en   = in_beat || ((state_r == ST_SCAN) && !cur_match && !scan_last);
  assign ram_rd_addr = in_beat ? '0 : IDX_W'(idx_r + 1'b1);
  assign ram_wr_en   = commit;
  assign ram_wr_addr = slot;
  assign ram_wr_data = {page_r, use_count_r};

  assign page_ext = {{OFFSET_BITS{1'b0}}, page_r};
  assign slot_ext = {{(tlb_pkg::ADDR_W - IDX_W){1'b0}}, slot};

  assign res_valid       = commit;
  assign res.hit         = hit_r;
  assign res.page_number = page_ext[tlb_pkg::PAGE_OUT_W-1:0];
  assign res.page_offset = offset_r;
  assign res.slot_used   = slot_ext[tlb_pkg::SLOT_OUT_W-1:0];
  assign res.evicted     = !hit_r && !have_empty_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_match || scan_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      use_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_beat) begin
        use_count_r <= use_count_r + 1'b1;
      end
      if (commit) begin
        valid_r[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      page_r       <= page_full[PAGE_W-1:0];
      offset_r     <= offset_full[tlb_pkg::OFFS_OUT_W-1:0];
      idx_r        <= '0;
      hit_r        <= 1'b0;
      have_empty_r <= 1'b0;
      have_lru_r   <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      if (cur_match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx_r;
      end else begin
        if (cur_valid) begin
          if (!have_lru_r || (rd_stamp < lru_stamp_r)) begin
            have_lru_r  <= 1'b1;
            lru_idx_r   <= idx_r;
            lru_stamp_r <= rd_stamp;
          end
        end else if (!have_empty_r) begin
          have_empty_r <= 1'b1;
          empty_idx_r  <= idx_r;
        end
        if (!scan_last) begin
          idx_r <= IDX_W'(idx_r + 1'b1);
        end
      end
    end
  end

endmodule
